[sv/icosahedral_zone_classifier_core_defines.svh]
// ----------------------------------------------------------------------------
// icosahedral zone classifier defines
// assertion macros used by the classifier rtl, clocked on i_clk and
// disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ICOSAHEDRAL_ZONE_CLASSIFIER_CORE_DEFINES_SVH
`define ICOSAHEDRAL_ZONE_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define IZC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IZC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/izc_pkg.sv]
// ----------------------------------------------------------------------------
// izc_pkg
// types, constants and register codes of the icosahedral zone classifier
// ----------------------------------------------------------------------------
`default_nettype none

package izc_pkg;

    localparam int NUM_ZONES   = 12;
    localparam int ZONE_W      = 4;
    localparam int COMP_W      = 16;
    localparam int DOT_W       = 32;
    localparam int FRAC_W      = 15;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - NUM_ZONES - 1 - ZONE_W;

    // vertex components in q1.15, a = b * golden ratio
    localparam logic signed [DOT_W-1:0] ICO_A = 32'sd27874;
    localparam logic signed [DOT_W-1:0] ICO_B = 32'sd17227;

    // threshold reset value, -1.0 in q1.15
    localparam logic signed [COMP_W-1:0] VIEW_COS_RST = 16'sh8000;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [DOT_W-1:0]  t_dot;
    typedef t_dot                     t_dot_arr [NUM_ZONES];
    typedef logic [ZONE_W-1:0]        t_zone;
    typedef logic [NUM_ZONES-1:0]     t_mask;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_VIEW_X   = 2'd0,
        CFG_VIEW_Y   = 2'd1,
        CFG_VIEW_Z   = 2'd2,
        CFG_VIEW_COS = 2'd3
    } t_cfg_idx;

    // configuration write bundle
    typedef struct packed {
        logic     we;
        t_cfg_idx addr;
        t_comp    data;
    } t_cfg_wr;

endpackage

`default_nettype wire

[sv/icosahedral_zone_classifier_core.sv]
// ----------------------------------------------------------------------------
// icosahedral zone classifier core
// nearest icosahedron vertex of a direction vector plus field-of-view mask
// ----------------------------------------------------------------------------
// result path: an accepted item is held in the input reg, then in the result reg
// throughput: one item per cycle unless stalled, single compare tree between regs
// the result register frees the input side while a result waits downstream
// reset: synchronous active low, clears both valid flags, view vector to zero
// and threshold to -1.0 so every zone is visible
// ----------------------------------------------------------------------------
`default_nettype none

`include "icosahedral_zone_classifier_core_defines.svh"

module icosahedral_zone_classifier_core (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // slave side
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // pos_x [15:0], pos_y [31:16], pos_z [47:32]
    input  wire  [izc_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    // master side
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    // zone [3:0], zone_in_view [4], view_mask [16:5], zero pad [23:17]
    output logic [izc_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // zone_valid [0]
    output logic                                 o_m_axis_tuser,
    // configuration write port
    input  wire                                  i_cfg_we,
    input  wire  [1:0]                           i_cfg_addr,
    input  wire  [izc_pkg::COMP_W-1:0]           i_cfg_wdata
);

    logic              r_in_valid;
    izc_pkg::t_comp    r_pos_x, r_pos_y, r_pos_z;
    logic              r_out_valid;
    izc_pkg::t_zone    r_zone;
    logic              r_zone_valid;
    logic              r_zone_in_view;
    izc_pkg::t_mask    r_view_mask;

    logic              w_out_free;
    logic              w_in_take;
    izc_pkg::t_cfg_wr  w_cfg;
    izc_pkg::t_mask    w_mask;
    izc_pkg::t_dot_arr w_dot;
    izc_pkg::t_zone    w_best;
    logic              w_nonzero;

    logic              n_out_valid;
    izc_pkg::t_zone    n_zone;
    logic              n_zone_in_view;

    // handshake: each stage moves when the one after it is free
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_pos_x <= izc_pkg::t_comp'(i_s_axis_tdata[15:0]);
            r_pos_y <= izc_pkg::t_comp'(i_s_axis_tdata[31:16]);
            r_pos_z <= izc_pkg::t_comp'(i_s_axis_tdata[47:32]);
        end
    end

    // configuration registers and view mask
    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.addr = izc_pkg::t_cfg_idx'(i_cfg_addr);
    assign w_cfg.data = izc_pkg::t_comp'(i_cfg_wdata);

    izc_view_cfg u_view_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .o_mask  (w_mask)
    );

    // vertex dot products and winner
    izc_dot u_pos_dot (
        .i_x   (r_pos_x),
        .i_y   (r_pos_y),
        .i_z   (r_pos_z),
        .o_dot (w_dot)
    );

    izc_argmax u_argmax (
        .i_dot  (w_dot),
        .o_zone (w_best)
    );

    // zero vector forces zone 0 and clears the visible bit
    assign w_nonzero      = (r_pos_x != '0) || (r_pos_y != '0) || (r_pos_z != '0);
    assign n_zone         = w_nonzero ? w_best : '0;
    assign n_zone_in_view = w_nonzero && w_mask[n_zone];
    assign n_out_valid    = r_in_valid;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_in_valid) begin
            r_zone         <= n_zone;
            r_zone_valid   <= w_nonzero;
            r_zone_in_view <= n_zone_in_view;
            r_view_mask    <= w_mask;
        end
    end

    // output packing
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_zone_valid;
    assign o_m_axis_tdata  = {{izc_pkg::OUT_PAD_W{1'b0}}, r_view_mask, r_zone_in_view, r_zone};

    // checks
    `IZC_ASSERT_SAME(a_zero_vec_result, r_out_valid && !r_zone_valid, (r_zone == '0) && !r_zone_in_view, "zero vector result not cleared")
    `IZC_ASSERT_SAME(a_zone_range, r_out_valid, r_zone < izc_pkg::t_zone'(izc_pkg::NUM_ZONES), "zone index out of range")
    `IZC_ASSERT_SAME(a_in_view_bit, r_out_valid && r_zone_valid, r_zone_in_view == r_view_mask[r_zone], "visible bit disagrees with mask")
    `IZC_ASSERT_NEXT(a_stage_advance, r_in_valid && w_out_free, r_out_valid, "item lost between input and result register")

endmodule

`default_nettype wire

[sv/izc_dot.sv]
// ----------------------------------------------------------------------------
// izc_dot
// dot products of one vector with all twelve icosahedron vertices
// ----------------------------------------------------------------------------
`default_nettype none

module izc_dot (
    input  izc_pkg::t_comp    i_x,
    input  izc_pkg::t_comp    i_y,
    input  izc_pkg::t_comp    i_z,
    output izc_pkg::t_dot_arr o_dot
);

    izc_pkg::t_dot w_ax, w_bx, w_ay, w_by, w_az, w_bz;

    // six constant products shared by all vertices
    assign w_ax = izc_pkg::t_dot'(i_x) * izc_pkg::ICO_A;
    assign w_bx = izc_pkg::t_dot'(i_x) * izc_pkg::ICO_B;
    assign w_ay = izc_pkg::t_dot'(i_y) * izc_pkg::ICO_A;
    assign w_by = izc_pkg::t_dot'(i_y) * izc_pkg::ICO_B;
    assign w_az = izc_pkg::t_dot'(i_z) * izc_pkg::ICO_A;
    assign w_bz = izc_pkg::t_dot'(i_z) * izc_pkg::ICO_B;

    // vertices in the xy plane
    assign o_dot[0]  =  w_ax - w_by;
    assign o_dot[1]  =  w_ax + w_by;
    assign o_dot[2]  = -w_ax + w_by;
    assign o_dot[3]  = -w_ax - w_by;
    // vertices in the yz plane
    assign o_dot[4]  =  w_ay - w_bz;
    assign o_dot[5]  =  w_ay + w_bz;
    assign o_dot[6]  = -w_ay + w_bz;
    assign o_dot[7]  = -w_ay - w_bz;
    // vertices in the zx plane
    assign o_dot[8]  = -w_bx + w_az;
    assign o_dot[9]  =  w_bx + w_az;
    assign o_dot[10] =  w_bx - w_az;
    assign o_dot[11] = -w_bx - w_az;

endmodule

`default_nettype wire

[sv/izc_argmax.sv]
// ----------------------------------------------------------------------------
// izc_argmax
// compare tree picking the largest dot product, lowest index on a tie
// ----------------------------------------------------------------------------
`default_nettype none

module izc_argmax (
    input  izc_pkg::t_dot_arr i_dot,
    output izc_pkg::t_zone    o_zone
);

    izc_pkg::t_dot  w_v1 [6];
    izc_pkg::t_zone w_i1 [6];
    izc_pkg::t_dot  w_v2 [3];
    izc_pkg::t_zone w_i2 [3];
    izc_pkg::t_dot  w_v3 [2];
    izc_pkg::t_zone w_i3 [2];

    // right side wins only when strictly greater, so lower index keeps ties
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            if (i_dot[2*k+1] > i_dot[2*k]) begin
                w_v1[k] = i_dot[2*k+1];
                w_i1[k] = izc_pkg::t_zone'(2*k+1);
            end else begin
                w_v1[k] = i_dot[2*k];
                w_i1[k] = izc_pkg::t_zone'(2*k);
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (w_v1[2*k+1] > w_v1[2*k]) begin
                w_v2[k] = w_v1[2*k+1];
                w_i2[k] = w_i1[2*k+1];
            end else begin
                w_v2[k] = w_v1[2*k];
                w_i2[k] = w_i1[2*k];
            end
        end
        // odd leftover passes straight to the last level
        if (w_v2[1] > w_v2[0]) begin
            w_v3[0] = w_v2[1];
            w_i3[0] = w_i2[1];
        end else begin
            w_v3[0] = w_v2[0];
            w_i3[0] = w_i2[0];
        end
        w_v3[1] = w_v2[2];
        w_i3[1] = w_i2[2];
        if (w_v3[1] > w_v3[0]) begin
            o_zone = w_i3[1];
        end else begin
            o_zone = w_i3[0];
        end
    end

endmodule

`default_nettype wire

[sv/izc_view_cfg.sv]
// ----------------------------------------------------------------------------
// izc_view_cfg
// view vector and threshold registers, field-of-view zone mask
// ----------------------------------------------------------------------------
`default_nettype none

module izc_view_cfg (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  izc_pkg::t_cfg_wr  i_cfg,
    output izc_pkg::t_mask    o_mask
);

    izc_pkg::t_comp    r_view_x, r_view_y, r_view_z, r_view_cos;
    izc_pkg::t_dot_arr w_dot;
    izc_pkg::t_dot     w_thr;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_x   <= '0;
            r_view_y   <= '0;
            r_view_z   <= '0;
            r_view_cos <= izc_pkg::VIEW_COS_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.addr)
                izc_pkg::CFG_VIEW_X:   r_view_x   <= i_cfg.data;
                izc_pkg::CFG_VIEW_Y:   r_view_y   <= i_cfg.data;
                izc_pkg::CFG_VIEW_Z:   r_view_z   <= i_cfg.data;
                izc_pkg::CFG_VIEW_COS: r_view_cos <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // view dot products in q2.30
    izc_dot u_view_dot (
        .i_x   (r_view_x),
        .i_y   (r_view_y),
        .i_z   (r_view_z),
        .o_dot (w_dot)
    );

    // threshold scaled from q1.15 to q2.30
    assign w_thr = izc_pkg::t_dot'(r_view_cos) <<< izc_pkg::FRAC_W;

    always_comb begin
        for (int i = 0; i < izc_pkg::NUM_ZONES; i++) begin
            o_mask[i] = (w_dot[i] > w_thr);
        end
    end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the icosahedral zone classifier core: streams
// direction vectors in, predicts nearest zone, zone_valid, zone_in_view and
// the view mask for each accepted item, and checks every result in order
// across several view settings and idle patterns on both sides
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ZA             = 27874;
    localparam int ZB             = 17227;
    localparam int SEG_ITEMS      = 235;
    localparam int NUM_SEGS       = 8;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 3000;
    localparam int TAIL_CYCLES    = 8;
    localparam int MAX_REPORTS    = 50;

    // one classified item as seen on the master side
    typedef struct packed {
        izc_pkg::t_zone zone;
        logic           zone_valid;
        logic           in_view;
        izc_pkg::t_mask view_mask;
    } t_zone_result;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [izc_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [izc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            cfg_we    = 1'b0;
    logic [1:0]                      cfg_addr  = '0;
    logic [izc_pkg::COMP_W-1:0]      cfg_wdata = '0;

    logic tx_pause = 1'b0;
    logic rx_hold  = 1'b0;
    logic hold_go  = 1'b0;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;

    int mismatch_count = 0;
    int result_count   = 0;
    int stall_cycles   = 0;

    // vertex directions of the unit icosahedron in q1.15
    int zone_axis [izc_pkg::NUM_ZONES][3] = '{
        '{ ZA, -ZB,   0}, '{ ZA,  ZB,   0}, '{-ZA,  ZB,   0}, '{-ZA, -ZB,   0},
        '{  0,  ZA, -ZB}, '{  0,  ZA,  ZB}, '{  0, -ZA,  ZB}, '{  0, -ZA, -ZB},
        '{-ZB,   0,  ZA}, '{ ZB,   0,  ZA}, '{ ZB,   0, -ZA}, '{-ZB,   0, -ZA}
    };

    // bench copy of the view registers, indexed by register code
    izc_pkg::t_comp view_reg [4] = '{16'sd0, 16'sd0, 16'sd0, izc_pkg::VIEW_COS_RST};

    logic [izc_pkg::IN_TDATA_W-1:0] pending_pos [$];
    t_zone_result                   expected_zones [$];
    t_zone_result                   zone_want;

    icosahedral_zone_classifier_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [izc_pkg::IN_TDATA_W-1:0] pack_pos(izc_pkg::t_comp x,
                                                               izc_pkg::t_comp y,
                                                               izc_pkg::t_comp z);
        return {z, y, x};
    endfunction

    // append one item to the sender queue
    function automatic void queue_pos(logic [izc_pkg::IN_TDATA_W-1:0] pos);
        pending_pos = {pending_pos, pos};
    endfunction

    // nearest zone by largest dot product, lowest index on a tie, plus view mask
    function automatic t_zone_result classify_pos(logic [izc_pkg::IN_TDATA_W-1:0] pos);
        longint       p [3];
        longint       dot;
        longint       best_dot;
        longint       thr;
        int           best;
        logic         nonzero;
        t_zone_result r;
        p[0] = $signed(pos[15:0]);
        p[1] = $signed(pos[31:16]);
        p[2] = $signed(pos[47:32]);
        nonzero = (p[0] != 0) || (p[1] != 0) || (p[2] != 0);
        best = 0;
        best_dot = p[0] * zone_axis[0][0] + p[1] * zone_axis[0][1] + p[2] * zone_axis[0][2];
        for (int i = 1; i < izc_pkg::NUM_ZONES; i++) begin
            dot = p[0] * zone_axis[i][0] + p[1] * zone_axis[i][1] + p[2] * zone_axis[i][2];
            if (dot > best_dot) begin
                best_dot = dot;
                best = i;
            end
        end
        thr = longint'(view_reg[izc_pkg::CFG_VIEW_COS]) * 32768;
        r.view_mask = '0;
        for (int i = 0; i < izc_pkg::NUM_ZONES; i++) begin
            dot = longint'(view_reg[izc_pkg::CFG_VIEW_X]) * zone_axis[i][0]
                + longint'(view_reg[izc_pkg::CFG_VIEW_Y]) * zone_axis[i][1]
                + longint'(view_reg[izc_pkg::CFG_VIEW_Z]) * zone_axis[i][2];
            r.view_mask[i] = (dot > thr);
        end
        // zero vector: zone 0, not valid, not in view
        r.zone       = nonzero ? izc_pkg::t_zone'(best) : '0;
        r.zone_valid = nonzero;
        r.in_view    = nonzero ? r.view_mask[best] : 1'b0;
        return r;
    endfunction

    // random direction: mostly full range, some tiny, near-vertex and axis-plane ones
    function automatic logic [izc_pkg::IN_TDATA_W-1:0] rand_pos();
        izc_pkg::t_comp c [3];
        int             k;
        int             sh;
        k  = $urandom_range(izc_pkg::NUM_ZONES - 1);
        sh = $urandom_range(14);
        for (int i = 0; i < 3; i++) c[i] = izc_pkg::t_comp'($urandom);
        case ($urandom_range(9))
            6, 7: for (int i = 0; i < 3; i++)
                c[i] = izc_pkg::t_comp'(int'($urandom_range(4)) - 2);
            8: for (int i = 0; i < 3; i++)
                c[i] = izc_pkg::t_comp'((zone_axis[k][i] >>> sh) + int'($urandom_range(2)) - 1);
            9: begin
                c[$urandom_range(2)] = '0;
                if ($urandom_range(1) == 1) c[$urandom_range(2)] = '0;
            end
            default: ;
        endcase
        return pack_pos(c[0], c[1], c[2]);
    endfunction

    task automatic report_mismatch(string what, int got_v, int want_v);
        if (mismatch_count < MAX_REPORTS)
            $display("result %0d: %s got %0d expected %0d", result_count, what, got_v, want_v);
        mismatch_count++;
    endtask

    task automatic write_view_reg(izc_pkg::t_cfg_idx idx, izc_pkg::t_comp val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        view_reg[idx] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_view(izc_pkg::t_comp vx, izc_pkg::t_comp vy, izc_pkg::t_comp vz,
                            izc_pkg::t_comp vcos);
        write_view_reg(izc_pkg::CFG_VIEW_X, vx);
        write_view_reg(izc_pkg::CFG_VIEW_Y, vy);
        write_view_reg(izc_pkg::CFG_VIEW_Z, vz);
        write_view_reg(izc_pkg::CFG_VIEW_COS, vcos);
    endtask

    // wait until every queued item is in and every result is out
    task automatic drain_zone_results();
        while (pending_pos.size() != 0 || s_tvalid || expected_zones.size() != 0)
            @(posedge clk);
    endtask

    // sender: present the queue head, hold it until accepted, predict on accept
    always @(posedge clk) begin
        if (s_tvalid && s_tready) begin
            expected_zones = {expected_zones, classify_pos(s_tdata)};
            void'(pending_pos.pop_front());
        end
        if (!s_tvalid || s_tready) begin
            if (pending_pos.size() != 0 && !tx_pause && $urandom_range(99) >= tx_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_pos[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, check each result against the oldest prediction
    always @(posedge clk) begin
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_zones.size() == 0) begin
                report_mismatch("unexpected result, zone", m_tdata[3:0], -1);
            end else begin
                zone_want = expected_zones.pop_front();
                if (m_tdata[3:0] != zone_want.zone)
                    report_mismatch("zone", m_tdata[3:0], zone_want.zone);
                if (m_tuser != zone_want.zone_valid)
                    report_mismatch("zone_valid", m_tuser, zone_want.zone_valid);
                if (m_tdata[4] != zone_want.in_view)
                    report_mismatch("zone_in_view", m_tdata[4], zone_want.in_view);
                if (m_tdata[16:5] != zone_want.view_mask)
                    report_mismatch("view_mask", m_tdata[16:5], zone_want.view_mask);
                if (m_tdata[23:17] != '0)
                    report_mismatch("pad bits", m_tdata[23:17], 0);
            end
            result_count++;
        end
    end

    // long receiver hold-off so the block fills and backs up the input
    initial begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus and phase control
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items under reset registers: zero vector, axis ties,
        // field extremes and every vertex direction
        queue_pos(pack_pos(0, 0, 0));
        queue_pos(pack_pos(1, 0, 0));
        queue_pos(pack_pos(-1, 0, 0));
        queue_pos(pack_pos(0, 1, 0));
        queue_pos(pack_pos(0, -1, 0));
        queue_pos(pack_pos(0, 0, 1));
        queue_pos(pack_pos(0, 0, -1));
        queue_pos(pack_pos(16'sh7fff, 16'sh7fff, 16'sh7fff));
        queue_pos(pack_pos(16'sh8000, 16'sh8000, 16'sh8000));
        queue_pos(pack_pos(16'sh7fff, 16'sh8000, 0));
        queue_pos(pack_pos(16'sh8000, 16'sh7fff, 16'sh8000));
        for (int k = 0; k < izc_pkg::NUM_ZONES; k++)
            queue_pos(pack_pos(izc_pkg::t_comp'(zone_axis[k][0]),
                               izc_pkg::t_comp'(zone_axis[k][1]),
                               izc_pkg::t_comp'(zone_axis[k][2])));
        drain_zone_results();

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            case (seg)
                0: set_view(16'sh7fff, 0, 0, 0);
                1: set_view(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff);
                2: set_view(0, 0, 0, 0);
                3: set_view(ZA, ZB, 0, 16'sd16384);
                7: set_view(0, 0, 0, 16'sh8000);
                default: set_view(izc_pkg::t_comp'($urandom), izc_pkg::t_comp'($urandom),
                                  izc_pkg::t_comp'($urandom), izc_pkg::t_comp'($urandom));
            endcase
            case (seg % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 79; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 79; end
                default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
            endcase
            if (seg == 0) hold_go = 1'b1;
            for (int n = 0; n < SEG_ITEMS; n++) queue_pos(rand_pos());
            // sender stops halfway and waits for every result before going on
            if (seg == 3) begin
                while (pending_pos.size() > SEG_ITEMS / 2) @(posedge clk);
                tx_pause <= 1'b1;
                @(posedge clk);
                while (s_tvalid || expected_zones.size() != 0) @(posedge clk);
                tx_pause <= 1'b0;
            end
            drain_zone_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_zones.size() != 0)
            report_mismatch("results missing", 0, expected_zones.size());
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
